// ===== rtl/hrsp_pkg.sv =====
// Shared types and constants for the HTTP request stream parser.
`timescale 1ns / 1ps
`default_nettype none
package hrsp_pkg;

    // Parser phases across the request
    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_METHOD    = 4'd1,
        PH_GAP1      = 4'd2,
        PH_PATH      = 4'd3,
        PH_QSTART    = 4'd4,
        PH_QUERY     = 4'd5,
        PH_GAP2      = 4'd6,
        PH_VERSION   = 4'd7,
        PH_EOL       = 4'd8,
        PH_HEADER    = 4'd9,
        PH_BODYSTART = 4'd10,
        PH_BODY      = 4'd11
    } t_phase;

    // Byte classification codes
    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_PATH    = 3'd1;
    localparam logic [2:0] KIND_QUERY   = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_HEADER  = 3'd4;
    localparam logic [2:0] KIND_BODY    = 3'd5;
    localparam logic [2:0] KIND_SKIP    = 3'd6;

    // Status codes, lowest nonzero wins
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_TAG    = 2'd1;
    localparam logic [1:0] ST_BAD_METH  = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    localparam logic [3:0] METH_NONE = 4'd0;
    localparam int         NUM_METH  = 9;

    // Method names, left aligned in a 7-byte window, zero padded
    localparam logic [55:0] METH_NAME [NUM_METH] = '{
        {"GET",     32'h0},
        {"POST",    24'h0},
        {"PUT",     32'h0},
        {"DELETE",   8'h0},
        {"HEAD",    24'h0},
        {"OPTIONS"       },
        {"TRACE",   16'h0},
        {"CONNECT"       },
        {"PATCH",   16'h0}
    };
    localparam logic [2:0] METH_LEN [NUM_METH] = '{
        3'd3, 3'd4, 3'd3, 3'd6, 3'd4, 3'd7, 3'd5, 3'd7, 3'd5
    };

    localparam logic [111:0] CL_NAME  = "Content-Length";
    localparam logic [39:0]  VER_TAG  = "HTTP/";
    localparam logic [31:0]  HTTP_TAG = "HTTP";

    localparam logic [4:0] CL_NAME_LEN = 5'd14;
    localparam logic [4:0] CL_DIGIT_POS = 5'd16;
    localparam logic [2:0] VER_TAG_LEN = 3'd5;
    localparam logic [4:0] LINE_POS_MAX = 5'd31;
    localparam logic [4:0] METH_WIN_BYTES = 5'd7;

    localparam logic [5:0] MAX_HEADER_LINES = 6'd32;
    localparam logic [5:0] MAX_QUERY_PARAMS = 6'd32;
    localparam logic [5:0] CFG_RESET_LIMIT  = 6'd32;

    localparam int LENGTH_BITS = 32;

    // Register word indexes on the config port
    localparam logic REG_MAX_HEADERS = 1'b0;
    localparam logic REG_MAX_QUERIES = 1'b1;

    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

endpackage
`default_nettype wire

// ===== rtl/http_request_stream_parser_top.sv =====
// HTTP request stream parser: byte tagging, counters and request status.
// Each accepted input word gives its result word on o_valid in the following cycle.
// Throughput: 1 word per cycle while o_stall is low; one shallow combinational pass per byte.
// The result register takes a new word while the previous one leaves, so the
// input stalls only while a finished result is held downstream.
// Reset (i_rst_n low, synchronous): leading-whitespace phase, flags clear, limits 32.
`timescale 1ns / 1ps
`default_nettype none
module http_request_stream_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_byte_kind,
    output logic             o_starts_item,
    output logic             o_done_res,
    output logic [1:0]       o_status,
    output logic [3:0]       o_method_code,
    output logic [31:0]      o_declared_len,
    output logic [5:0]       o_header_count,
    output logic [5:0]       o_query_count,
    output logic             o_length_mismatch,
    output logic             o_overflow
);
    import hrsp_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // ---------------- configuration registers ----------------
    logic [5:0] r_max_headers;
    logic [5:0] r_max_queries;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_headers <= CFG_RESET_LIMIT;
            r_max_queries <= CFG_RESET_LIMIT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_HEADERS: r_max_headers <= pwdata[5:0];
                REG_MAX_QUERIES: r_max_queries <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_HEADERS: prdata = {26'd0, r_max_headers};
            REG_MAX_QUERIES: prdata = {26'd0, r_max_queries};
            default:         prdata = 32'd0;
        endcase
    end

    // Effective limits: the register clamped to the built-in maximum
    logic [5:0] hdr_limit;
    logic [5:0] qry_limit;
    assign hdr_limit = (r_max_headers < MAX_HEADER_LINES) ? r_max_headers : MAX_HEADER_LINES;
    assign qry_limit = (r_max_queries < MAX_QUERY_PARAMS) ? r_max_queries : MAX_QUERY_PARAMS;

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic in_acc;

    // Hold the input only while a finished result is itself held downstream
    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;
    assign o_valid = r_out_valid;

    // ---------------- parser state ----------------
    t_phase                 r_phase;
    logic [55:0]            r_meth_win;
    logic [31:0]            r_tag_win;
    logic                   r_tag_found;
    logic [4:0]             r_line_pos;
    logic                   r_prefix_ok;
    logic [LENGTH_BITS-1:0] r_len_acc;
    logic [5:0]             r_hdr_seen;
    logic [5:0]             r_qry_seen;
    logic [LENGTH_BITS-1:0] r_body_cnt;
    logic [1:0]             r_status;
    logic [3:0]             r_method;
    logic [2:0]             r_ver_skip;
    logic                   r_nl_run;
    logic                   r_ovf;

    t_phase                 n_phase;
    logic [55:0]            n_meth_win;
    logic [31:0]            n_tag_win;
    logic                   n_tag_found;
    logic [4:0]             n_line_pos;
    logic                   n_prefix_ok;
    logic [LENGTH_BITS-1:0] n_len_acc;
    logic [5:0]             n_hdr_seen;
    logic [5:0]             n_qry_seen;
    logic [LENGTH_BITS-1:0] n_body_cnt;
    logic [1:0]             n_status;
    logic [3:0]             n_method;
    logic [2:0]             n_ver_skip;
    logic                   n_nl_run;
    logic                   n_ovf;

    // result fields of this word
    logic [2:0] res_kind;
    logic       res_start;
    logic       res_mismatch;

    // Match the method token against the known names in order, first hit wins
    function automatic logic [3:0] decode_method(input logic [55:0] win,
                                                 input logic [4:0]  lp);
        logic [2:0]  n;
        logic [55:0] tok;
        logic [55:0] mask;
        logic [3:0]  code;
        n    = (lp < METH_WIN_BYTES) ? lp[2:0] : 3'd7;
        // left-align the captured bytes
        tok  = win << {3'd7 - n, 3'b000};
        code = METH_NONE;
        for (int m = 0; m < NUM_METH; m++) begin
            mask = ~({56{1'b1}} >> {METH_LEN[m], 3'b000});
            if (code == METH_NONE && METH_LEN[m] <= n && (tok & mask) == METH_NAME[m]) begin
                code = 4'(m + 1);
            end
        end
        return code;
    endfunction

    // Keep the lowest nonzero status
    function automatic logic [1:0] raise(input logic [1:0] cur, input logic [1:0] code);
        return (cur == ST_OK || code < cur) ? code : cur;
    endfunction

    always_comb begin
        logic       ws;
        logic       do_end;
        logic [3:0] dec;
        logic [7:0] b;
        logic [3:0] digit;
        logic [LENGTH_BITS+3:0] prod;
        logic [LENGTH_BITS-1:0] base;

        b  = i_data_byte;
        ws = (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
        do_end = 1'b0;
        digit  = 4'(b - CH_ZERO);
        base   = '0;
        prod   = '0;

        n_phase     = r_phase;
        n_meth_win  = r_meth_win;
        n_tag_win   = r_tag_win;
        n_tag_found = r_tag_found;
        n_line_pos  = r_line_pos;
        n_prefix_ok = r_prefix_ok;
        n_len_acc   = r_len_acc;
        n_hdr_seen  = r_hdr_seen;
        n_qry_seen  = r_qry_seen;
        n_body_cnt  = r_body_cnt;
        n_status    = r_status;
        n_method    = r_method;
        n_ver_skip  = r_ver_skip;
        n_nl_run    = r_nl_run;
        n_ovf       = r_ovf;

        res_kind     = KIND_SKIP;
        res_start    = 1'b0;
        res_mismatch = 1'b0;

        // Search for the version tag on everything up to the end of the request line
        if (r_phase <= PH_EOL) begin
            n_tag_win = {r_tag_win[23:0], b};
            if (n_tag_win == HTTP_TAG) n_tag_found = 1'b1;
            if (r_phase >= PH_METHOD && b == CH_LF && !n_tag_found) begin
                n_status = raise(n_status, ST_NO_TAG);
            end
        end

        unique case (r_phase)
            PH_LEAD: begin
                if (!ws) begin
                    n_phase    = PH_METHOD;
                    res_kind   = KIND_METHOD;
                    res_start  = 1'b1;
                    n_meth_win = {48'd0, b};
                    n_line_pos = 5'd1;
                end
            end
            PH_METHOD: begin
                if (ws) begin
                    do_end  = 1'b1;
                    n_phase = PH_GAP1;
                end else begin
                    res_kind = KIND_METHOD;
                    if (r_line_pos < METH_WIN_BYTES) n_meth_win = {r_meth_win[47:0], b};
                    if (r_line_pos < LINE_POS_MAX) n_line_pos = r_line_pos + 5'd1;
                end
            end
            PH_GAP1, PH_PATH: begin
                if (ws) begin
                    if (r_phase == PH_PATH) n_phase = PH_GAP2;
                end else if (b == CH_QM) begin
                    if (r_qry_seen < qry_limit) n_qry_seen = r_qry_seen + 6'd1;
                    else n_ovf = 1'b1;
                    n_phase = PH_QSTART;
                end else begin
                    res_kind  = KIND_PATH;
                    res_start = (r_phase == PH_GAP1);
                    n_phase   = PH_PATH;
                end
            end
            PH_QSTART, PH_QUERY: begin
                if (ws) begin
                    n_phase = PH_GAP2;
                end else if (b == CH_AMP) begin
                    if (r_qry_seen < qry_limit) n_qry_seen = r_qry_seen + 6'd1;
                    else n_ovf = 1'b1;
                    n_phase = PH_QSTART;
                end else begin
                    res_kind  = KIND_QUERY;
                    res_start = (r_phase == PH_QSTART);
                    n_phase   = PH_QUERY;
                end
            end
            PH_GAP2, PH_VERSION: begin
                if (ws) begin
                    if (r_phase == PH_VERSION) begin
                        if (r_ver_skip < VER_TAG_LEN || !r_prefix_ok) begin
                            n_status = raise(n_status, ST_MALFORMED);
                        end
                        if (b == CH_LF) begin
                            n_phase  = PH_HEADER;
                            n_nl_run = 1'b1;
                        end else begin
                            n_phase = PH_EOL;
                        end
                    end
                end else begin
                    if (r_phase == PH_GAP2) begin
                        n_phase     = PH_VERSION;
                        n_ver_skip  = 3'd0;
                        n_prefix_ok = 1'b1;
                    end
                    // Strip the version prefix, checking it as it goes by
                    if (n_ver_skip < VER_TAG_LEN) begin
                        n_prefix_ok = n_prefix_ok &&
                            (b == VER_TAG[{3'd4 - n_ver_skip, 3'b000} +: 8]);
                        n_ver_skip  = n_ver_skip + 3'd1;
                    end else begin
                        res_kind = KIND_VERSION;
                        if (n_ver_skip == VER_TAG_LEN) begin
                            res_start  = 1'b1;
                            n_ver_skip = 3'd6;
                        end
                    end
                end
            end
            PH_EOL: begin
                if (b == CH_LF) begin
                    n_phase  = PH_HEADER;
                    n_nl_run = 1'b1;
                end
            end
            PH_HEADER: begin
                if (b == CH_LF) begin
                    // a blank line ends the headers
                    if (r_nl_run) n_phase = PH_BODYSTART;
                    else n_nl_run = 1'b1;
                end else if (b != CH_CR) begin
                    res_kind = KIND_HEADER;
                    if (r_nl_run) begin
                        res_start = 1'b1;
                        if (r_hdr_seen < hdr_limit) n_hdr_seen = r_hdr_seen + 6'd1;
                        else n_ovf = 1'b1;
                        n_line_pos  = 5'd0;
                        n_prefix_ok = 1'b1;
                        n_nl_run    = 1'b0;
                    end
                    // Content-Length name check, then its decimal value
                    if (n_line_pos < CL_NAME_LEN) begin
                        n_prefix_ok = n_prefix_ok &&
                            (b == CL_NAME[{4'd13 - n_line_pos[3:0], 3'b000} +: 8]);
                    end else if (n_line_pos >= CL_DIGIT_POS && n_prefix_ok) begin
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            base = (n_line_pos == CL_DIGIT_POS) ? '0 : n_len_acc;
                            prod = ({4'd0, base} << 3) + ({4'd0, base} << 1)
                                 + {{LENGTH_BITS{1'b0}}, digit};
                            if (prod > {4'd0, LEN_MAX}) begin
                                n_len_acc = LEN_MAX;
                                n_ovf     = 1'b1;
                            end else begin
                                n_len_acc = prod[LENGTH_BITS-1:0];
                            end
                        end else begin
                            n_prefix_ok = 1'b0;
                        end
                    end
                    if (n_line_pos < LINE_POS_MAX) n_line_pos = n_line_pos + 5'd1;
                end
            end
            PH_BODYSTART, PH_BODY: begin
                res_kind  = KIND_BODY;
                res_start = (r_phase == PH_BODYSTART);
                n_phase   = PH_BODY;
                if (r_body_cnt < LEN_MAX) n_body_cnt = r_body_cnt + LENGTH_BITS'(1);
                else n_ovf = 1'b1;
            end
            default: begin
                n_phase = PH_LEAD;
            end
        endcase

        // End of request: close out an open method and flag an unfinished line
        if (i_last) begin
            if (n_phase == PH_METHOD) do_end = 1'b1;
        end

        dec = decode_method(n_meth_win, n_line_pos);
        if (do_end) begin
            n_method = dec;
            if (dec == METH_NONE) n_status = raise(n_status, ST_BAD_METH);
        end

        if (i_last) begin
            if (n_phase <= PH_EOL && !n_tag_found) n_status = raise(n_status, ST_NO_TAG);
            if (n_phase <= PH_VERSION) n_status = raise(n_status, ST_MALFORMED);
            res_mismatch = (n_body_cnt != n_len_acc);
        end
    end

    // Advance parser state on each accepted word; drop back to reset after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_last)) begin
            r_phase     <= PH_LEAD;
            r_meth_win  <= '0;
            r_tag_win   <= '0;
            r_tag_found <= 1'b0;
            r_line_pos  <= '0;
            r_prefix_ok <= 1'b1;
            r_len_acc   <= '0;
            r_hdr_seen  <= '0;
            r_qry_seen  <= '0;
            r_body_cnt  <= '0;
            r_status    <= ST_OK;
            r_method    <= METH_NONE;
            r_ver_skip  <= '0;
            r_nl_run    <= 1'b0;
            r_ovf       <= 1'b0;
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_meth_win  <= n_meth_win;
            r_tag_win   <= n_tag_win;
            r_tag_found <= n_tag_found;
            r_line_pos  <= n_line_pos;
            r_prefix_ok <= n_prefix_ok;
            r_len_acc   <= n_len_acc;
            r_hdr_seen  <= n_hdr_seen;
            r_qry_seen  <= n_qry_seen;
            r_body_cnt  <= n_body_cnt;
            r_status    <= n_status;
            r_method    <= n_method;
            r_ver_skip  <= n_ver_skip;
            r_nl_run    <= n_nl_run;
            r_ovf       <= n_ovf;
        end
    end

    // Result register: valid is control, the payload loads on accept only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            o_out_byte        <= i_data_byte;
            o_byte_kind       <= res_kind;
            o_starts_item     <= res_start;
            o_done_res        <= i_last;
            o_status          <= n_status;
            o_method_code     <= n_method;
            o_declared_len    <= n_len_acc;
            o_header_count    <= n_hdr_seen;
            o_query_count     <= n_qry_seen;
            o_length_mismatch <= res_mismatch;
            o_overflow        <= n_ovf;
        end
    end

endmodule
`default_nettype wire
